FILE: design/sadc_pkg.sv
`timescale 1ns / 1ps

package sadc_pkg;

   // Width of the conversion word as seen on the result channel
   localparam int SAMPLE_WIDTH = 24;

   localparam int TIMEOUT_WIDTH = 17;
   localparam int ATTEMPT_WIDTH = 3;
   localparam int HALF_WIDTH    = 8;
   localparam int RESET_WIDTH   = 16;
   localparam int CSR_WIDTH     = 17;
   localparam int CSR_IDX_WIDTH = 3;

   localparam logic [TIMEOUT_WIDTH-1:0] TIMEOUT_SLOW_RST = 17'd120000;
   localparam logic [TIMEOUT_WIDTH-1:0] TIMEOUT_FAST_RST = 17'd30000;
   localparam logic [TIMEOUT_WIDTH-1:0] TIMEOUT_TEMP_RST = 17'd60000;
   localparam logic [ATTEMPT_WIDTH-1:0] ATTEMPT_RST      = 3'd3;
   localparam logic [HALF_WIDTH-1:0]    BIT_HALF_RST     = 8'd5;
   localparam logic [HALF_WIDTH-1:0]    EXTRA_HALF_RST   = 8'd1;
   localparam logic [RESET_WIDTH-1:0]   RESET_LEN_RST    = 16'd200;

   typedef enum logic [CSR_IDX_WIDTH-1:0] {
      REG_TIMEOUT_SLOW = 3'd0,
      REG_TIMEOUT_FAST = 3'd1,
      REG_TIMEOUT_TEMP = 3'd2,
      REG_ATTEMPTS     = 3'd3,
      REG_BIT_HALF     = 3'd4,
      REG_EXTRA_HALF   = 3'd5,
      REG_RESET_LEN    = 3'd6
   } reg_index_type;

   typedef enum logic [1:0] {
      OP_TICK  = 2'd0,
      OP_READ  = 2'd1,
      OP_RESET = 2'd2
   } operation_type;

   typedef enum logic [1:0] {
      MODE_SLOW    = 2'd0,
      MODE_FAST    = 2'd1,
      MODE_TEMP    = 2'd2,
      MODE_INVALID = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_TIMEOUT  = 2'd1,
      ST_BAD_MODE = 2'd2
   } status_type;

   typedef enum logic [6:0] {
      PH_IDLE  = 7'b0000001,
      PH_WAIT  = 7'b0000010,
      PH_HIGH  = 7'b0000100,
      PH_LOW   = 7'b0001000,
      PH_XHIGH = 7'b0010000,
      PH_XLOW  = 7'b0100000,
      PH_RESET = 7'b1000000
   } phase_type;

   typedef struct packed {
      logic [TIMEOUT_WIDTH-1:0] timeout_slow;
      logic [TIMEOUT_WIDTH-1:0] timeout_fast;
      logic [TIMEOUT_WIDTH-1:0] timeout_temp;
      logic [ATTEMPT_WIDTH-1:0] attempt_limit;
      logic [HALF_WIDTH-1:0]    bit_half;
      logic [HALF_WIDTH-1:0]    extra_half;
      logic [RESET_WIDTH-1:0]   reset_len;
   } cfg_type;

   typedef struct packed {
      logic                    sck_level;
      logic                    busy_res;
      logic                    done_res;
      logic [SAMPLE_WIDTH-1:0] sample;
      status_type              status;
   } result_type;

   // Mode-select pulses that follow the data bits
   function automatic logic [1:0] extra_pulses(input logic [1:0] mode);
      logic [1:0] count;
      case (mode)
         MODE_SLOW: count = 2'd1;
         MODE_FAST: count = 2'd3;
         MODE_TEMP: count = 2'd2;
         default:   count = 2'd0;
      endcase
      return count;
   endfunction

endpackage

FILE: design/sadc_regs.sv
`timescale 1ns / 1ps

module sadc_regs (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_valid,
   input  logic [sadc_pkg::CSR_IDX_WIDTH-1:0]     csr_index,
   input  logic [sadc_pkg::CSR_WIDTH-1:0]         csr_wdata,
   output sadc_pkg::cfg_type                      cfg
);
   import sadc_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_TIMEOUT_SLOW: cfg_in.timeout_slow  = csr_wdata[TIMEOUT_WIDTH-1:0];
            REG_TIMEOUT_FAST: cfg_in.timeout_fast  = csr_wdata[TIMEOUT_WIDTH-1:0];
            REG_TIMEOUT_TEMP: cfg_in.timeout_temp  = csr_wdata[TIMEOUT_WIDTH-1:0];
            REG_ATTEMPTS:     cfg_in.attempt_limit = csr_wdata[ATTEMPT_WIDTH-1:0];
            REG_BIT_HALF:     cfg_in.bit_half      = csr_wdata[HALF_WIDTH-1:0];
            REG_EXTRA_HALF:   cfg_in.extra_half    = csr_wdata[HALF_WIDTH-1:0];
            REG_RESET_LEN:    cfg_in.reset_len     = csr_wdata[RESET_WIDTH-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.timeout_slow  <= TIMEOUT_SLOW_RST;
         cfg_ff.timeout_fast  <= TIMEOUT_FAST_RST;
         cfg_ff.timeout_temp  <= TIMEOUT_TEMP_RST;
         cfg_ff.attempt_limit <= ATTEMPT_RST;
         cfg_ff.bit_half      <= BIT_HALF_RST;
         cfg_ff.extra_half    <= EXTRA_HALF_RST;
         cfg_ff.reset_len     <= RESET_LEN_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: design/sadc_core.sv
`timescale 1ns / 1ps

module sadc_core #(
   parameter int SAMPLE_BITS = 24
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                step_en,
   input  logic [1:0]          operation,
   input  logic [1:0]          mode,
   input  logic                dout_level,
   input  sadc_pkg::cfg_type   cfg,
   output sadc_pkg::result_type result
);
   import sadc_pkg::*;

   localparam int BIT_CNT_WIDTH = $clog2(SAMPLE_BITS + 1);

   phase_type                  phase_ff,  phase_in;
   logic [TIMEOUT_WIDTH-1:0]   tick_ff,   tick_in;
   logic [BIT_CNT_WIDTH-1:0]   bit_ff,    bit_in;
   logic [SAMPLE_BITS-1:0]     shift_ff,  shift_in;
   logic [ATTEMPT_WIDTH-1:0]   att_ff,    att_in;
   logic [1:0]                 pulse_ff,  pulse_in;
   logic [1:0]                 mode_ff,   mode_in;

   logic [TIMEOUT_WIDTH-1:0]   tick_dec;
   logic [TIMEOUT_WIDTH-1:0]   half;
   logic [TIMEOUT_WIDTH-1:0]   xhalf;
   logic [ATTEMPT_WIDTH-1:0]   att_limit;
   logic [ATTEMPT_WIDTH-1:0]   att_dec;
   logic [BIT_CNT_WIDTH-1:0]   bit_inc;
   logic [1:0]                 pulse_dec;
   logic [SAMPLE_WIDTH-1:0]    word;
   result_type                 res;

   // A zero register acts as one
   function automatic logic [TIMEOUT_WIDTH-1:0] timeout_of(input cfg_type c,
                                                          input logic [1:0] m);
      logic [TIMEOUT_WIDTH-1:0] t;
      case (m)
         MODE_SLOW: t = c.timeout_slow;
         MODE_FAST: t = c.timeout_fast;
         MODE_TEMP: t = c.timeout_temp;
         default:   t = TIMEOUT_WIDTH'(c.attempt_limit);
      endcase
      return (t == '0) ? TIMEOUT_WIDTH'(1) : t;
   endfunction

   assign tick_dec  = tick_ff - TIMEOUT_WIDTH'(1);
   assign att_dec   = att_ff - ATTEMPT_WIDTH'(1);
   assign bit_inc   = bit_ff + BIT_CNT_WIDTH'(1);
   assign pulse_dec = pulse_ff - 2'd1;
   assign half      = (cfg.bit_half == '0) ? TIMEOUT_WIDTH'(1)
                                           : TIMEOUT_WIDTH'(cfg.bit_half);
   assign xhalf     = (cfg.extra_half == '0) ? TIMEOUT_WIDTH'(1)
                                             : TIMEOUT_WIDTH'(cfg.extra_half);
   assign att_limit = (cfg.attempt_limit == '0) ? ATTEMPT_WIDTH'(1) : cfg.attempt_limit;

   generate
      if (SAMPLE_BITS >= SAMPLE_WIDTH) begin : g_word_trunc
         assign word = shift_ff[SAMPLE_WIDTH-1:0];
      end else begin : g_word_ext
         assign word = {{(SAMPLE_WIDTH-SAMPLE_BITS){1'b0}}, shift_ff};
      end
   endgenerate

   always_comb begin
      phase_in  = phase_ff;
      tick_in   = tick_ff;
      bit_in    = bit_ff;
      shift_in  = shift_ff;
      att_in    = att_ff;
      pulse_in  = pulse_ff;
      mode_in   = mode_ff;
      res.sck_level = 1'b0;
      res.done_res  = 1'b0;
      res.sample    = '0;
      res.status    = ST_OK;
      case (phase_ff)
         PH_IDLE: begin
            if (operation == OP_READ) begin
               mode_in = mode;
               if (mode == MODE_INVALID) begin
                  res.done_res = 1'b1;
                  res.status   = ST_BAD_MODE;
               end else begin
                  att_in   = att_limit;
                  tick_in  = timeout_of(cfg, mode);
                  phase_in = PH_WAIT;
               end
            end else if (operation == OP_RESET) begin
               tick_in  = (cfg.reset_len == '0) ? TIMEOUT_WIDTH'(1)
                                                : TIMEOUT_WIDTH'(cfg.reset_len);
               phase_in = PH_RESET;
            end
         end
         PH_WAIT: begin
            if (!dout_level) begin
               shift_in = '0;
               bit_in   = '0;
               tick_in  = half;
               phase_in = PH_HIGH;
            end else begin
               tick_in = tick_dec;
               if (tick_dec == '0) begin
                  att_in = att_dec;
                  if (att_dec == '0) begin
                     res.done_res = 1'b1;
                     res.status   = ST_TIMEOUT;
                     phase_in     = PH_IDLE;
                  end else begin
                     tick_in = timeout_of(cfg, mode_ff);
                  end
               end
            end
         end
         PH_HIGH: begin
            res.sck_level = 1'b1;
            tick_in       = tick_dec;
            if (tick_dec == '0) begin
               shift_in = {shift_ff[SAMPLE_BITS-2:0], dout_level};
               tick_in  = half;
               phase_in = PH_LOW;
            end
         end
         PH_LOW: begin
            tick_in = tick_dec;
            if (tick_dec == '0) begin
               bit_in = bit_inc;
               if (bit_inc >= BIT_CNT_WIDTH'(SAMPLE_BITS)) begin
                  pulse_in = extra_pulses(mode_ff);
                  tick_in  = xhalf;
                  phase_in = PH_XHIGH;
               end else begin
                  tick_in  = half;
                  phase_in = PH_HIGH;
               end
            end
         end
         PH_XHIGH: begin
            res.sck_level = 1'b1;
            tick_in       = tick_dec;
            if (tick_dec == '0) begin
               tick_in  = xhalf;
               phase_in = PH_XLOW;
            end
         end
         PH_XLOW: begin
            tick_in = tick_dec;
            if (tick_dec == '0) begin
               pulse_in = pulse_dec;
               if (pulse_dec == '0) begin
                  res.done_res = 1'b1;
                  res.status   = ST_OK;
                  res.sample   = word;
                  phase_in     = PH_IDLE;
               end else begin
                  tick_in  = xhalf;
                  phase_in = PH_XHIGH;
               end
            end
         end
         PH_RESET: begin
            res.sck_level = 1'b1;
            tick_in       = tick_dec;
            if (tick_dec == '0) begin
               phase_in = PH_IDLE;
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
      res.busy_res = (phase_in != PH_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         tick_ff  <= '0;
         bit_ff   <= '0;
         shift_ff <= '0;
         att_ff   <= '0;
         pulse_ff <= '0;
         mode_ff  <= '0;
      end else if (step_en) begin
         phase_ff <= phase_in;
         tick_ff  <= tick_in;
         bit_ff   <= bit_in;
         shift_ff <= shift_in;
         att_ff   <= att_in;
         pulse_ff <= pulse_in;
         mode_ff  <= mode_in;
      end
   end

   assign result = res;

endmodule

FILE: design/serial_adc_frame_reader.sv
`timescale 1ns / 1ps

// Reader for a two-wire 24-bit sigma-delta converter, one transaction per tick.
//
// Request channel (req_*): one transaction per timing tick carries the
// operation (plain tick, start read, start reset pulse), the mode for a read
// and the level seen on the converter's data-out line. Each request gives
// exactly one response transaction (rsp_*) with the clock level to drive,
// busy, a one-tick done flag, the sample and the status.
// Configuration (csr_*): register index and write data, accepted in every
// cycle; write only while no request is outstanding.
// An accepted request waits in the request register for a state step, which
// loads its result into the response register for the receiver to take.
// Throughput: one tick per cycle while the receiver does not stall, set by the
// single state step between the request and response registers.
// Reset clears both registers' valid flags and the sequencer (idle, counters
// zero) and loads the configuration defaults.
// When the receiver stalls, the response holds; the request register still
// takes one more transaction if it is empty, then req_stall rises until the response moves.

module serial_adc_frame_reader #(
   parameter int SAMPLE_BITS = 24
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [1:0]                          req_operation,
   input  logic [1:0]                          req_mode,
   input  logic                                req_dout_level,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_sck_level,
   output logic                                rsp_busy_res,
   output logic                                rsp_done_res,
   output logic [sadc_pkg::SAMPLE_WIDTH-1:0]   rsp_sample,
   output logic [1:0]                          rsp_status,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [sadc_pkg::CSR_IDX_WIDTH-1:0]  csr_index,
   input  logic [sadc_pkg::CSR_WIDTH-1:0]      csr_wdata
);
   import sadc_pkg::*;

   cfg_type    cfg;
   result_type step_res;

   // Request register
   logic       req_vld_ff, req_vld_in;
   logic [1:0] op_ff;
   logic [1:0] mode_ff;
   logic       dout_ff;

   // Response register
   logic       rsp_vld_ff, rsp_vld_in;
   result_type rsp_ff;

   logic       req_take;
   logic       step_en;

   // Advance when a request is held and the response register is empty or being drained
   assign step_en   = req_vld_ff && (!rsp_vld_ff || !rsp_stall);
   assign req_stall = req_vld_ff && !step_en;
   assign req_take  = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   always_comb begin
      req_vld_in = req_vld_ff;
      if (req_take) begin
         req_vld_in = 1'b1;
      end else if (step_en) begin
         req_vld_in = 1'b0;
      end
   end

   always_comb begin
      rsp_vld_in = rsp_vld_ff && rsp_stall;
      if (step_en) begin
         rsp_vld_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_vld_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         req_vld_ff <= req_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   // Capture the request payload on acceptance
   always_ff @(posedge clock) begin
      if (req_take) begin
         op_ff   <= req_operation;
         mode_ff <= req_mode;
         dout_ff <= req_dout_level;
      end
   end

   // Load the response only on a state step, hold it otherwise
   always_ff @(posedge clock) begin
      if (step_en) begin
         rsp_ff <= step_res;
      end
   end

   sadc_regs u_regs (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   sadc_core #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .step_en    (step_en),
      .operation  (op_ff),
      .mode       (mode_ff),
      .dout_level (dout_ff),
      .cfg        (cfg),
      .result     (step_res)
   );

   assign rsp_valid     = rsp_vld_ff;
   assign rsp_sck_level = rsp_ff.sck_level;
   assign rsp_busy_res  = rsp_ff.busy_res;
   assign rsp_done_res  = rsp_ff.done_res;
   assign rsp_sample    = rsp_ff.sample;
   assign rsp_status    = rsp_ff.status;

endmodule

FILE: design/sadc_checker.sv
`timescale 1ns / 1ps

module sadc_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              rsp_valid,
   input  logic                              rsp_stall,
   input  logic                              rsp_sck_level,
   input  logic                              rsp_busy_res,
   input  logic                              rsp_done_res,
   input  logic [sadc_pkg::SAMPLE_WIDTH-1:0] rsp_sample,
   input  logic [1:0]                        rsp_status
);
   import sadc_pkg::*;

   // A finished read leaves the clock low and the sequencer idle
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_done_res |-> !rsp_busy_res && !rsp_sck_level)
      else $error("done transaction with clock high or still busy");

   // Status is only meaningful alongside done
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_OK) |-> rsp_done_res)
      else $error("error status without done");

   // Sample word only appears on a successful finish
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_sample != '0) |-> rsp_done_res && (rsp_status == ST_OK))
      else $error("sample outside a successful done transaction");

   // Stalled response holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_sample)
         && $stable(rsp_status) && $stable(rsp_done_res)
         && $stable(rsp_busy_res) && $stable(rsp_sck_level))
      else $error("stalled response changed");

endmodule

bind serial_adc_frame_reader sadc_checker u_checker (.*);

FILE: test/serial_adc_frame_reader_tb.sv
`timescale 1ns / 1ps

module serial_adc_frame_reader_tb;
   import sadc_pkg::*;

   // Operation code 3 is unassigned and must behave as a plain tick
   localparam logic [1:0]   OP_UNUSED      = 2'd3;
   // Register index with no register behind it: the write must be dropped
   localparam logic [2:0]   UNMAPPED_INDEX = 3'd7;
   localparam int           MAX_REPORTS    = 10;
   // Settling margin before a register write or the final verdict
   localparam int           SETTLE_CYCLES  = 6;
   localparam int unsigned  CYCLE_LIMIT    = 1000000;

   // Predicts the pin sequence tick by tick and checks each response
   class adc_reader_scoreboard;
      logic [TIMEOUT_WIDTH-1:0] cfg [7];
      phase_type                phase;
      logic [TIMEOUT_WIDTH-1:0] tick_count;
      logic [4:0]               bits_taken;
      logic [SAMPLE_WIDTH-1:0]  shift_word;
      logic [ATTEMPT_WIDTH-1:0] attempts_left;
      logic [1:0]               pulses_left;
      mode_type                 read_mode;
      result_type               tick_results [$];
      int unsigned              mismatches, checked;
      int unsigned              reads_ok, timeouts, bad_modes, reset_pulses;

      function new();
         cfg[REG_TIMEOUT_SLOW] = TIMEOUT_SLOW_RST;
         cfg[REG_TIMEOUT_FAST] = TIMEOUT_FAST_RST;
         cfg[REG_TIMEOUT_TEMP] = TIMEOUT_TEMP_RST;
         cfg[REG_ATTEMPTS]     = ATTEMPT_RST;
         cfg[REG_BIT_HALF]     = BIT_HALF_RST;
         cfg[REG_EXTRA_HALF]   = EXTRA_HALF_RST;
         cfg[REG_RESET_LEN]    = RESET_LEN_RST;
         phase         = PH_IDLE;
         tick_count    = '0;
         bits_taken    = '0;
         shift_word    = '0;
         attempts_left = '0;
         pulses_left   = '0;
         read_mode     = MODE_SLOW;
         mismatches    = 0;
         checked       = 0;
         reads_ok      = 0;
         timeouts      = 0;
         bad_modes     = 0;
         reset_pulses  = 0;
      endfunction

      // A zero in any count register behaves as one
      function logic [TIMEOUT_WIDTH-1:0] at_least_one(logic [TIMEOUT_WIDTH-1:0] v);
         return (v == 0) ? 17'd1 : v;
      endfunction

      function logic [TIMEOUT_WIDTH-1:0] ready_timeout(logic [1:0] m);
         return at_least_one(cfg[m]);
      endfunction

      function logic [TIMEOUT_WIDTH-1:0] bit_half();
         return at_least_one(cfg[REG_BIT_HALF]);
      endfunction

      function int wait_budget(logic [1:0] m);
         return int'(ready_timeout(m)) * int'(at_least_one(cfg[REG_ATTEMPTS]));
      endfunction

      function logic [1:0] select_pulses(mode_type m);
         case (m)
            MODE_SLOW: return 2'd1;
            MODE_FAST: return 2'd3;
            MODE_TEMP: return 2'd2;
            default:   return 2'd0;
         endcase
      endfunction

      function void write_register(logic [CSR_IDX_WIDTH-1:0] idx,
                                   logic [CSR_WIDTH-1:0] data);
         case (idx)
            REG_TIMEOUT_SLOW, REG_TIMEOUT_FAST, REG_TIMEOUT_TEMP: cfg[idx] = data;
            REG_ATTEMPTS:                 cfg[idx] = {14'd0, data[ATTEMPT_WIDTH-1:0]};
            REG_BIT_HALF, REG_EXTRA_HALF: cfg[idx] = {9'd0, data[HALF_WIDTH-1:0]};
            REG_RESET_LEN:                cfg[idx] = {1'b0, data[RESET_WIDTH-1:0]};
            default: ;
         endcase
      endfunction

      // Advance the sequencer by one accepted tick and queue its response
      function void note_request(logic [1:0] op, logic [1:0] md, logic dout);
         result_type               r;
         logic [TIMEOUT_WIDTH-1:0] limit;
         logic [TIMEOUT_WIDTH-1:0] half;
         logic [TIMEOUT_WIDTH-1:0] xhalf;
         r     = '0;
         half  = bit_half();
         xhalf = at_least_one(cfg[REG_EXTRA_HALF]);
         case (phase)
            PH_IDLE: begin
               if (op == OP_READ) begin
                  read_mode = mode_type'(md);
                  if (md == MODE_INVALID) begin
                     r.done_res = 1'b1;
                     r.status   = ST_BAD_MODE;
                     bad_modes++;
                  end else begin
                     limit         = at_least_one(cfg[REG_ATTEMPTS]);
                     attempts_left = limit[ATTEMPT_WIDTH-1:0];
                     tick_count    = ready_timeout(md);
                     phase         = PH_WAIT;
                  end
               end else if (op == OP_RESET) begin
                  tick_count = at_least_one(cfg[REG_RESET_LEN]);
                  phase      = PH_RESET;
                  reset_pulses++;
               end
            end
            PH_WAIT: begin
               if (!dout) begin
                  shift_word = '0;
                  bits_taken = '0;
                  tick_count = half;
                  phase      = PH_HIGH;
               end else begin
                  tick_count = tick_count - 1'b1;
                  if (tick_count == 0) begin
                     attempts_left = attempts_left - 1'b1;
                     if (attempts_left == 0) begin
                        r.done_res = 1'b1;
                        r.status   = ST_TIMEOUT;
                        phase      = PH_IDLE;
                        timeouts++;
                     end else begin
                        tick_count = ready_timeout(read_mode);
                     end
                  end
               end
            end
            PH_HIGH: begin
               r.sck_level = 1'b1;
               tick_count  = tick_count - 1'b1;
               if (tick_count == 0) begin
                  shift_word = {shift_word[SAMPLE_WIDTH-2:0], dout};
                  tick_count = half;
                  phase      = PH_LOW;
               end
            end
            PH_LOW: begin
               tick_count = tick_count - 1'b1;
               if (tick_count == 0) begin
                  bits_taken = bits_taken + 1'b1;
                  if (bits_taken >= SAMPLE_WIDTH) begin
                     pulses_left = select_pulses(read_mode);
                     tick_count  = xhalf;
                     phase       = PH_XHIGH;
                  end else begin
                     tick_count = half;
                     phase      = PH_HIGH;
                  end
               end
            end
            PH_XHIGH: begin
               r.sck_level = 1'b1;
               tick_count  = tick_count - 1'b1;
               if (tick_count == 0) begin
                  tick_count = xhalf;
                  phase      = PH_XLOW;
               end
            end
            PH_XLOW: begin
               tick_count = tick_count - 1'b1;
               if (tick_count == 0) begin
                  pulses_left = pulses_left - 1'b1;
                  if (pulses_left == 0) begin
                     r.done_res = 1'b1;
                     r.status   = ST_OK;
                     r.sample   = shift_word;
                     phase      = PH_IDLE;
                     reads_ok++;
                  end else begin
                     tick_count = xhalf;
                     phase      = PH_XHIGH;
                  end
               end
            end
            PH_RESET: begin
               r.sck_level = 1'b1;
               tick_count  = tick_count - 1'b1;
               if (tick_count == 0) phase = PH_IDLE;
            end
            default: phase = PH_IDLE;
         endcase
         r.busy_res = (phase != PH_IDLE);
         tick_results.push_back(r);
      endfunction

      function void compare_field(string field, logic [SAMPLE_WIDTH-1:0] want,
                                  logic [SAMPLE_WIDTH-1:0] got);
         if (want !== got) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("response %0d: %s expected 0x%0h, got 0x%0h",
                        checked, field, want, got);
         end
      endfunction

      function void check_result(result_type got);
         result_type want;
         if (tick_results.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("response %0d arrived with no tick outstanding", checked);
         end else begin
            want = tick_results.pop_front();
            compare_field("sck_level", SAMPLE_WIDTH'(want.sck_level),
                          SAMPLE_WIDTH'(got.sck_level));
            compare_field("busy", SAMPLE_WIDTH'(want.busy_res), SAMPLE_WIDTH'(got.busy_res));
            compare_field("done", SAMPLE_WIDTH'(want.done_res), SAMPLE_WIDTH'(got.done_res));
            compare_field("sample", want.sample, got.sample);
            compare_field("status", SAMPLE_WIDTH'(want.status), SAMPLE_WIDTH'(got.status));
         end
         checked++;
      endfunction

      function int pending();
         return tick_results.size();
      endfunction
   endclass

   logic                      clock          = 1'b0;
   logic                      reset          = 1'b1;
   logic                      req_valid      = 1'b0;
   logic                      req_stall;
   logic [1:0]                req_operation  = OP_TICK;
   logic [1:0]                req_mode       = MODE_SLOW;
   logic                      req_dout_level = 1'b0;
   logic                      rsp_valid;
   logic                      rsp_stall      = 1'b0;
   logic                      rsp_sck_level;
   logic                      rsp_busy_res;
   logic                      rsp_done_res;
   logic [SAMPLE_WIDTH-1:0]   rsp_sample;
   logic [1:0]                rsp_status;
   logic                      csr_valid      = 1'b0;
   logic                      csr_ready;
   logic [CSR_IDX_WIDTH-1:0]  csr_index      = REG_TIMEOUT_SLOW;
   logic [CSR_WIDTH-1:0]      csr_wdata      = '0;

   result_type                seen_rsp;
   adc_reader_scoreboard      sb;
   int unsigned               ticks_sent     = 0;
   int unsigned               cycle_count    = 0;
   bit                        idling_on      = 1'b1;

   serial_adc_frame_reader #(
      .SAMPLE_BITS(SAMPLE_WIDTH)
   ) u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_operation  (req_operation),
      .req_mode       (req_mode),
      .req_dout_level (req_dout_level),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_sck_level  (rsp_sck_level),
      .rsp_busy_res   (rsp_busy_res),
      .rsp_done_res   (rsp_done_res),
      .rsp_sample     (rsp_sample),
      .rsp_status     (rsp_status),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always #5 clock = ~clock;

   assign seen_rsp = {rsp_sck_level, rsp_busy_res, rsp_done_res, rsp_sample, rsp_status};

   // Sample both channels at the rising edge: advance the prediction on an
   // accepted request transaction, check an accepted response transaction
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall)
            sb.note_request(req_operation, req_mode, req_dout_level);
         if (rsp_valid && !rsp_stall)
            sb.check_result(seen_rsp);
      end
   end

   // Receiver back-pressure: while idling is on, raise stall now and then for bursts of random length
   always begin
      @(negedge clock);
      if (idling_on && !reset && $urandom_range(0, 5) == 0) begin
         rsp_stall <= 1'b1;
         repeat ($urandom_range(1, 4)) @(negedge clock);
         rsp_stall <= 1'b0;
      end
   end

   // Hang guard: end the run if the cycle count runs out
   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("serial_adc_frame_reader: mismatch");
      $finish;
   end

   // Mostly plain ticks; now and then a request the busy sequencer must drop
   function automatic logic [1:0] noise_op();
      case ($urandom_range(0, 9))
         0:       return OP_READ;
         1:       return OP_RESET;
         2:       return OP_UNUSED;
         default: return OP_TICK;
      endcase
   endfunction

   // Present one tick transaction at the falling edge and hold it until
   // accepted; leave valid high so back-to-back ticks need no re-raise
   task automatic send_tick(input logic [1:0] op, input logic [1:0] md, input logic dout);
      if (idling_on && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_operation  <= op;
      req_mode       <= md;
      req_dout_level <= dout;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      ticks_sent++;
   endtask

   // Feed ticks until the sequencer is idle; pull data-out low in a ready
   // wait so that no wait drags on
   task automatic drain();
      while (sb.phase != PH_IDLE)
         send_tick(noise_op(), 2'($urandom_range(0, 3)),
                   (sb.phase == PH_WAIT) ? 1'b0 : 1'($urandom_range(0, 1)));
   endtask

   // One read: request, hold data-out high for the given number of wait
   // ticks, signal ready, then present the word MSB first, one bit per
   // clock period, and let the mode-select pulses run out
   task automatic read_frame(input logic [1:0] md, input logic [SAMPLE_WIDTH-1:0] word,
                             input int delay, input bit noisy);
      int k;
      int b;
      send_tick(OP_READ, md, 1'($urandom_range(0, 1)));
      k = 0;
      while (sb.phase == PH_WAIT && k < delay) begin
         send_tick(noisy ? noise_op() : OP_TICK, 2'($urandom_range(0, 3)), 1'b1);
         k++;
      end
      if (sb.phase == PH_WAIT)
         send_tick(noisy ? noise_op() : OP_TICK, 2'($urandom_range(0, 3)), 1'b0);
      if (sb.phase == PH_HIGH)
         for (b = SAMPLE_WIDTH - 1; b >= 0; b--)
            repeat (2 * sb.bit_half())
               send_tick(noisy ? noise_op() : OP_TICK, 2'($urandom_range(0, 3)), word[b]);
      drain();
   endtask

   task automatic reset_pulse();
      send_tick(OP_RESET, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
      drain();
   endtask

   // Drain the sequencer, drop valid, wait for every predicted response, then let the pipeline empty
   task automatic quiesce();
      drain();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // One register write transaction; valid stays high for the next one
   task automatic write_csr(input logic [CSR_IDX_WIDTH-1:0] idx,
                            input logic [CSR_WIDTH-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      sb.write_register(idx, data);
      @(negedge clock);
   endtask

   task automatic configure_all(input logic [CSR_WIDTH-1:0] slow, input logic [CSR_WIDTH-1:0] fast,
                                input logic [CSR_WIDTH-1:0] temp, input logic [CSR_WIDTH-1:0] tries,
                                input logic [CSR_WIDTH-1:0] half, input logic [CSR_WIDTH-1:0] xhalf,
                                input logic [CSR_WIDTH-1:0] rlen);
      write_csr(REG_TIMEOUT_SLOW, slow);
      write_csr(REG_TIMEOUT_FAST, fast);
      write_csr(REG_TIMEOUT_TEMP, temp);
      write_csr(REG_ATTEMPTS, tries);
      write_csr(REG_BIT_HALF, half);
      write_csr(REG_EXTRA_HALF, xhalf);
      write_csr(REG_RESET_LEN, rlen);
      csr_valid <= 1'b0;
   endtask

   // Short timings keep reads brief; junk in the bits above each register's
   // width must be dropped
   task automatic configure_random();
      logic [CSR_WIDTH-1:0] tries;
      logic [CSR_WIDTH-1:0] half;
      logic [CSR_WIDTH-1:0] xhalf;
      logic [CSR_WIDTH-1:0] rlen;
      tries = CSR_WIDTH'($urandom);
      half  = CSR_WIDTH'($urandom);
      half[HALF_WIDTH-1:0] = HALF_WIDTH'($urandom_range(0, 4));
      xhalf = CSR_WIDTH'($urandom);
      xhalf[HALF_WIDTH-1:0] = HALF_WIDTH'($urandom_range(0, 3));
      rlen  = CSR_WIDTH'($urandom);
      rlen[RESET_WIDTH-1:0] = RESET_WIDTH'($urandom_range(0, 24));
      configure_all(CSR_WIDTH'($urandom_range(0, 40)), CSR_WIDTH'($urandom_range(0, 40)),
                    CSR_WIDTH'($urandom_range(0, 40)), tries, half, xhalf, rlen);
   endtask

   // Random episodes: mostly whole reads with random words and ready
   // delays (some long enough to run out of attempts), the rest reset
   // pulses and stray ticks
   task automatic run_random(input int unsigned count);
      int unsigned first;
      int          pick;
      int          delay;
      logic [1:0]  md;
      first = ticks_sent;
      while (ticks_sent - first < count) begin
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            md    = ($urandom_range(0, 9) == 0) ? MODE_INVALID : 2'($urandom_range(0, 2));
            delay = $urandom_range(0, 1) ? $urandom_range(0, 3)
                                         : $urandom_range(0, sb.wait_budget(md) + 2);
            read_frame(md, SAMPLE_WIDTH'($urandom), delay, 1'($urandom_range(0, 1)));
         end else if (pick < 85) begin
            reset_pulse();
         end else begin
            send_tick(noise_op(), 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
            drain();
         end
      end
   endtask

   initial begin
      sb = new();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset defaults: one read with ready at once
      read_frame(MODE_SLOW, SAMPLE_WIDTH'($urandom), 0, 1'b0);
      quiesce();

      // A write to an index with no register, then the shortest timings
      write_csr(UNMAPPED_INDEX, 17'h1FFFF);
      configure_all(17'd1, 17'd1, 17'd1, 17'd1, 17'd1, 17'd1, 17'd1);
      read_frame(MODE_INVALID, '0, 0, 1'b0);
      reset_pulse();
      read_frame(MODE_SLOW, {SAMPLE_WIDTH{1'b1}}, 0, 1'b0);
      read_frame(MODE_FAST, {SAMPLE_WIDTH{1'b0}}, 0, 1'b0);
      read_frame(MODE_TEMP, 24'h5A3C96, 0, 1'b1);
      // Data-out never goes low: the only attempt times out
      read_frame(MODE_FAST, '0, 1000, 1'b0);
      send_tick(OP_UNUSED, MODE_INVALID, 1'b1);
      quiesce();

      // Zero in every register behaves as one
      configure_all('0, '0, '0, '0, '0, '0, '0);
      read_frame(MODE_TEMP, '0, 1000, 1'b0);
      read_frame(MODE_SLOW, SAMPLE_WIDTH'($urandom), 0, 1'b1);
      reset_pulse();
      quiesce();

      repeat (4) begin
         configure_random();
         run_random(220);
         quiesce();
      end

      // Last part: longest ready timeouts, most attempts, and no idling on
      // either side
      idling_on = 1'b0;
      configure_all(17'h1FFFF, 17'h1FFFF, 17'h1FFFF, 17'd7, 17'd2, 17'd9, 17'd120);
      read_frame(MODE_FAST, SAMPLE_WIDTH'($urandom), 3, 1'b1);
      reset_pulse();
      quiesce();

      $display("%0d ticks checked: %0d reads completed, %0d timed out, %0d rejected mode",
               sb.checked, sb.reads_ok, sb.timeouts, sb.bad_modes);
      $display("%0d converter reset pulses, %0d mismatches", sb.reset_pulses, sb.mismatches);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("serial_adc_frame_reader: match");
      end else begin
         $display("serial_adc_frame_reader: mismatch");
      end
      $finish;
   end

endmodule
